FILE: rtl/core/tfn_pkg.sv
// ============================================================================
// tfn_pkg
// Shared types and constants for the triangle face normal pipeline.
// ============================================================================
package tfn_pkg;

    // One triangle, three vertices in signed Q8.8.
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by_coord;
        logic signed [15:0] bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } t_tri_in;

    // One unit normal in signed Q2.14 with the degenerate flag.
    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               degenerate;
    } t_norm_out;

    localparam int EDGE_W  = 17;   // exact edge difference
    localparam int PROD_W  = 34;   // exact edge product
    localparam int CROSS_W = 35;   // exact cross component
    localparam int PTOP_W  = 6;    // index of the top set bit of a cross magnitude
    localparam int NORM_TOP = 23;  // bit to which the largest magnitude is aligned
    localparam int NORM_W  = NORM_TOP + 1;
    localparam int SQ_W    = 2 * NORM_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int RAD_W   = SUM_W + 12;   // sum of squares times 4096
    localparam int ROOT_STEPS = RAD_W / 2;  // root bits, one per step
    localparam int RES_W   = RAD_W + 1;
    localparam int LEN_W   = ROOT_STEPS;
    localparam int NUM_W   = NORM_W + 21;  // shifted magnitude plus rounding term
    localparam int QUO_W   = 16;
    localparam int DIV_W   = NUM_W + 2;
    localparam int UNIT_MAG = 16384;

    // Cross product as it leaves the front part: components kept signed.
    typedef struct packed {
        logic [2:0][CROSS_W-1:0] cr;
        logic                    degen;
    } t_front_item;

    // Per-item values that travel alongside the root and divide stages.
    typedef struct packed {
        logic [2:0][NORM_W-1:0] w;
        logic [2:0]             sgn;
        logic                   degen;
    } t_side;

    // State of one step of the square root.
    typedef struct packed {
        logic [RAD_W-1:0] v;
        logic [RES_W-1:0] r;
    } t_root;

    // State of one step of the three divisions.
    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][QUO_W-1:0] q;
    } t_div;

endpackage

FILE: rtl/core/tfn_front.sv
// ============================================================================
// tfn_front
// Accepts triangles, forms the edge vectors and their exact cross product,
// and classifies each triangle as degenerate or not.
// ============================================================================
module tfn_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tfn_pkg::t_tri_in     i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tfn_pkg::t_front_item o_item
);

    logic [2:0] r_v;
    logic       en;

    logic signed [tfn_pkg::EDGE_W-1:0] r_ex, r_ey, r_ez, r_fx, r_fy, r_fz;
    logic signed [tfn_pkg::PROD_W-1:0] r_p [0:5];
    tfn_pkg::t_front_item              r_item;

    logic signed [tfn_pkg::CROSS_W-1:0] n_cr [0:2];

    // The three stages move together unless the last one cannot hand over.
    assign en      = !r_v[2] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[2];
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // Cross components from the registered products.
    always_comb begin
        n_cr[0] = {r_p[0][tfn_pkg::PROD_W-1], r_p[0]} - {r_p[1][tfn_pkg::PROD_W-1], r_p[1]};
        n_cr[1] = {r_p[2][tfn_pkg::PROD_W-1], r_p[2]} - {r_p[3][tfn_pkg::PROD_W-1], r_p[3]};
        n_cr[2] = {r_p[4][tfn_pkg::PROD_W-1], r_p[4]} - {r_p[5][tfn_pkg::PROD_W-1], r_p[5]};
    end

    // Edges, then products, then cross product and classification.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex <= {i_data.cx[15], i_data.cx} - {i_data.bx[15], i_data.bx};
            r_ey <= {i_data.cy[15], i_data.cy} - {i_data.by_coord[15], i_data.by_coord};
            r_ez <= {i_data.cz[15], i_data.cz} - {i_data.bz[15], i_data.bz};
            r_fx <= {i_data.ax[15], i_data.ax} - {i_data.bx[15], i_data.bx};
            r_fy <= {i_data.ay[15], i_data.ay} - {i_data.by_coord[15], i_data.by_coord};
            r_fz <= {i_data.az[15], i_data.az} - {i_data.bz[15], i_data.bz};

            r_p[0] <= r_ey * r_fz;
            r_p[1] <= r_ez * r_fy;
            r_p[2] <= r_ez * r_fx;
            r_p[3] <= r_ex * r_fz;
            r_p[4] <= r_ex * r_fy;
            r_p[5] <= r_ey * r_fx;

            r_item.cr[0] <= n_cr[0];
            r_item.cr[1] <= n_cr[1];
            r_item.cr[2] <= n_cr[2];
            r_item.degen <= (n_cr[0] == '0) && (n_cr[1] == '0) && (n_cr[2] == '0);
        end
    end

endmodule

FILE: rtl/core/tfn_queue.sv
// ============================================================================
// tfn_queue
// Short first-in first-out queue between the front and back parts.
// ============================================================================
module tfn_queue #(
    parameter int P_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  tfn_pkg::t_front_item i_push_data,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output tfn_pkg::t_front_item o_pop_data
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    tfn_pkg::t_front_item r_mem [0:P_DEPTH-1];
    logic [PTR_W-1:0]     r_wr, r_rd;
    logic [CNT_W-1:0]     r_cnt;
    logic                 push, pop;

    assign o_push_ready = (r_cnt != CNT_W'(P_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

FILE: rtl/core/tfn_back.sv
// ============================================================================
// tfn_back
// Normalises the cross product: aligns the magnitudes, takes the length by a
// pipelined square root and divides each component by a pipelined divider.
// ============================================================================
module tfn_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tfn_pkg::t_front_item i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tfn_pkg::t_norm_out   o_data
);

    localparam int ROOT_FIRST = 4;
    localparam int DIV_INIT   = ROOT_FIRST + tfn_pkg::ROOT_STEPS;
    localparam int N_STG      = DIV_INIT + 1 + tfn_pkg::QUO_W + 1;

    logic [N_STG-1:0] r_v;
    logic             en;

    // Stage registers.
    logic [2:0][tfn_pkg::CROSS_W-1:0] r_w0;
    logic [tfn_pkg::PTOP_W-1:0]       r_p0;
    logic [2:0]                       r_sgn0;
    logic                             r_dg0;
    tfn_pkg::t_side                   r_s1, r_s2, r_s3;
    logic [2:0][tfn_pkg::SQ_W-1:0]    r_sq;
    logic [tfn_pkg::SUM_W-1:0]        r_sum;
    tfn_pkg::t_root                   r_rt [0:tfn_pkg::ROOT_STEPS-1];
    tfn_pkg::t_side                   r_rs [0:tfn_pkg::ROOT_STEPS-1];
    tfn_pkg::t_div                    r_di [0:tfn_pkg::QUO_W];
    logic [tfn_pkg::LEN_W-1:0]        r_len [0:tfn_pkg::QUO_W];
    tfn_pkg::t_side                   r_ds [0:tfn_pkg::QUO_W];
    tfn_pkg::t_norm_out               r_out;

    logic [2:0][tfn_pkg::CROSS_W-1:0] n_mag;
    logic [tfn_pkg::CROSS_W-1:0]      n_or;
    logic [tfn_pkg::PTOP_W-1:0]       n_p;
    logic [tfn_pkg::SUM_W-1:0]        n_sum;
    logic [tfn_pkg::LEN_W-1:0]        n_len;
    tfn_pkg::t_div                    n_dinit;
    tfn_pkg::t_norm_out               n_out;

    // Aligns a magnitude so that the top bit of the largest lands on bit 23.
    function automatic logic [tfn_pkg::NORM_W-1:0] f_align(
        input logic [tfn_pkg::CROSS_W-1:0] w,
        input logic [tfn_pkg::PTOP_W-1:0]  p
    );
        logic [tfn_pkg::CROSS_W+tfn_pkg::NORM_TOP-1:0] t;
        t = {w, {tfn_pkg::NORM_TOP{1'b0}}} >> p;
        return t[tfn_pkg::NORM_W-1:0];
    endfunction

    // One digit of the square root.
    function automatic tfn_pkg::t_root f_root_step(
        input tfn_pkg::t_root x,
        input int             k
    );
        logic [tfn_pkg::RES_W-1:0] b;
        logic [tfn_pkg::RES_W-1:0] trial;
        tfn_pkg::t_root            y;
        b     = tfn_pkg::RES_W'(1) << (tfn_pkg::RAD_W - 2 - 2 * k);
        trial = x.r + b;
        if ({1'b0, x.v} >= trial) begin
            y.v = x.v - trial[tfn_pkg::RAD_W-1:0];
            y.r = (x.r >> 1) + b;
        end else begin
            y.v = x.v;
            y.r = x.r >> 1;
        end
        return y;
    endfunction

    // One quotient bit in each of the three lanes.
    function automatic tfn_pkg::t_div f_div_step(
        input tfn_pkg::t_div             x,
        input logic [tfn_pkg::LEN_W-1:0] len,
        input int                        j
    );
        logic [tfn_pkg::DIV_W-1:0] d;
        tfn_pkg::t_div             y;
        y = x;
        d = tfn_pkg::DIV_W'(len) << j;
        for (int i = 0; i < 3; i++) begin
            if ({2'b00, x.rem[i]} >= d) begin
                y.rem[i]  = x.rem[i] - d[tfn_pkg::NUM_W-1:0];
                y.q[i][j] = 1'b1;
            end
        end
        return y;
    endfunction

    assign en      = !r_v[N_STG-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[N_STG-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[N_STG-2:0], i_valid};
        end
    end

    // Magnitudes and the position of the top set bit among them.
    always_comb begin
        n_p = '0;
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_item.cr[i][tfn_pkg::CROSS_W-1] ? tfn_pkg::CROSS_W'(-i_item.cr[i])
                                                        : i_item.cr[i];
        end
        n_or = n_mag[0] | n_mag[1] | n_mag[2];
        for (int k = 0; k < tfn_pkg::CROSS_W; k++) begin
            if (n_or[k]) begin
                n_p = tfn_pkg::PTOP_W'(k);
            end
        end
    end

    // Radicand and the set-up of the divisions.
    always_comb begin
        n_sum = tfn_pkg::SUM_W'(r_sq[0]) + tfn_pkg::SUM_W'(r_sq[1])
              + tfn_pkg::SUM_W'(r_sq[2]);
        n_len = r_rt[tfn_pkg::ROOT_STEPS-1].r[tfn_pkg::LEN_W-1:0];
        if (n_len == '0) begin
            n_len = tfn_pkg::LEN_W'(1);
        end
        n_dinit.q = '0;
        for (int i = 0; i < 3; i++) begin
            n_dinit.rem[i] = tfn_pkg::NUM_W'({r_rs[tfn_pkg::ROOT_STEPS-1].w[i], 20'b0})
                           + tfn_pkg::NUM_W'(n_len >> 1);
        end
    end

    // Clamp, restore the sign and force a zero normal for a degenerate triangle.
    always_comb begin
        logic [tfn_pkg::QUO_W-1:0] q;
        logic [15:0]               m;
        for (int i = 0; i < 3; i++) begin
            q = r_di[tfn_pkg::QUO_W].q[i];
            m = (q > 16'(tfn_pkg::UNIT_MAG)) ? 16'(tfn_pkg::UNIT_MAG) : q;
            if (r_ds[tfn_pkg::QUO_W].degen) begin
                m = '0;
            end
            if (r_ds[tfn_pkg::QUO_W].sgn[i]) begin
                m = -m;
            end
            case (i)
                0: begin
                    n_out.nx = m;
                end
                1: begin
                    n_out.ny = m;
                end
                default: begin
                    n_out.nz = m;
                end
            endcase
        end
        n_out.degenerate = r_ds[tfn_pkg::QUO_W].degen;
    end

    // The datapath stages, all advancing on the common enable.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w0   <= n_mag;
            r_p0   <= n_p;
            r_sgn0 <= {i_item.cr[2][tfn_pkg::CROSS_W-1], i_item.cr[1][tfn_pkg::CROSS_W-1],
                       i_item.cr[0][tfn_pkg::CROSS_W-1]};
            r_dg0  <= i_item.degen;

            for (int i = 0; i < 3; i++) begin
                r_s1.w[i] <= f_align(r_w0[i], r_p0);
            end
            r_s1.sgn   <= r_sgn0;
            r_s1.degen <= r_dg0;

            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_s1.w[i] * r_s1.w[i];
            end
            r_s2 <= r_s1;

            // The sum of squares is registered beside the item it belongs to.
            r_sum <= n_sum;
            r_s3  <= r_s2;

            r_rt[0] <= f_root_step({{r_sum, 12'b0}, {tfn_pkg::RES_W{1'b0}}}, 0);
            r_rs[0] <= r_s3;
            for (int k = 1; k < tfn_pkg::ROOT_STEPS; k++) begin
                r_rt[k] <= f_root_step(r_rt[k-1], k);
                r_rs[k] <= r_rs[k-1];
            end

            r_di[0]  <= n_dinit;
            r_len[0] <= n_len;
            r_ds[0]  <= r_rs[tfn_pkg::ROOT_STEPS-1];
            for (int g = 1; g <= tfn_pkg::QUO_W; g++) begin
                r_di[g]  <= f_div_step(r_di[g-1], r_len[g-1], tfn_pkg::QUO_W - g);
                r_len[g] <= r_len[g-1];
                r_ds[g]  <= r_ds[g-1];
            end

            r_out <= n_out;
        end
    end

    // A degenerate result carries a zero normal.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[N_STG-1] && r_out.degenerate |-> r_out.nx == 0 && r_out.ny == 0 && r_out.nz == 0)
        else $error("degenerate result with a non-zero normal");

    // Every component stays within unit length.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[N_STG-1] |-> r_out.nx <= 16384 && r_out.nx >= -16384 &&
                         r_out.ny <= 16384 && r_out.ny >= -16384 &&
                         r_out.nz <= 16384 && r_out.nz >= -16384)
        else $error("normal component out of range");

    // A proper normal has one component of at least 9400, just under one over root three.
    a_unit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[N_STG-1] && !r_out.degenerate |->
            r_out.nx >= 9400 || r_out.nx <= -9400 || r_out.ny >= 9400 ||
            r_out.ny <= -9400 || r_out.nz >= 9400 || r_out.nz <= -9400)
        else $error("normal far from unit length");

endmodule

FILE: rtl/core/triangle_face_normal_top.sv
// ============================================================================
// triangle_face_normal_top
// Unit face normal of a triangle from three Q8.8 vertices, in Q2.14.
// ============================================================================
// One triangle is taken per clock cycle and one normal delivered per cycle
// when the output side does not stall. A triangle passes 3 register stages in
// the front part (edges, products, cross product), at least one in the queue
// and 53 in the back part; the back part's length is set by the 31-step
// square root and the 16-step divider. Both sides stall independently, the
// queue absorbing up to P_QUEUE_DEPTH cross products between them.
module triangle_face_normal_top #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tfn_pkg::t_tri_in    i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output tfn_pkg::t_norm_out  o_data
);

    logic                 f_valid, f_ready, q_valid, q_ready;
    tfn_pkg::t_front_item f_item, q_item;

    // Edge and cross product stages.
    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    // Queue between the two parts.
    tfn_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_item)
    );

    // Normalisation stages.
    tfn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
